// ===== design/ccc10_pkg.sv =====
`default_nettype none
package ccc10_pkg;

    localparam int unsigned MODULUS_DEF = 3329;
    localparam int unsigned LANES       = 4;
    localparam int unsigned COEFF_W     = 12;
    localparam int unsigned CODE_W      = 10;
    localparam int unsigned WORD_W      = LANES * CODE_W;
    localparam int unsigned CMP_MUL     = 966366;
    localparam int unsigned CMP_MUL_W   = 20;
    localparam int unsigned CMP_SHIFT1  = 22;
    localparam int unsigned CMP_SHIFT2  = 12;
    localparam int unsigned DEC_ROUND   = 512;

    typedef enum logic {
        REQ_COMPRESS   = 1'b0,
        REQ_DECOMPRESS = 1'b1
    } t_req_type;

    typedef struct packed {
        logic               req_type;
        logic [COEFF_W-1:0] coeff_0;
        logic [COEFF_W-1:0] coeff_1;
        logic [COEFF_W-1:0] coeff_2;
        logic [COEFF_W-1:0] coeff_3;
        logic [WORD_W-1:0]  packed_in;
    } t_req;

    typedef struct packed {
        logic [WORD_W-1:0]  packed_out;
        logic [COEFF_W-1:0] value_0;
        logic [COEFF_W-1:0] value_1;
        logic [COEFF_W-1:0] value_2;
        logic [COEFF_W-1:0] value_3;
    } t_rsp;

endpackage
`default_nettype wire

// ===== design/coeff_compress10_codec_core.sv =====
// Channel   Strobe / handshake        Payload
// request   i_start, o_busy (low)     i_req  (t_req)
// result    o_done (one cycle)        o_rsp  (t_rsp)
//
// Three register stages: form f and latch codes, multiply, then add/shift into
// the output register. A new request is taken every cycle. o_busy is held low,
// so the pipeline never stops; the result is a one-cycle transfer marked by
// o_done. Synchronous active-low reset clears the valid bits.
`default_nettype none
module coeff_compress10_codec_core
    import ccc10_pkg::*;
#(
    parameter int unsigned MODULUS = MODULUS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    output logic      o_busy,
    input  wire t_req i_req,
    output logic      o_done,
    output t_rsp      o_rsp
);

    logic [LANES*COEFF_W-1:0] w_coeffs;
    logic [WORD_W-1:0]        w_cmp;
    logic [LANES*COEFF_W-1:0] w_dec;

    logic       r_v1, r_v2, r_v3;
    logic       r_t1, r_t2;
    t_rsp       r_rsp;
    t_rsp       n_rsp;

    assign o_busy   = 1'b0;
    assign w_coeffs = {i_req.coeff_3, i_req.coeff_2, i_req.coeff_1, i_req.coeff_0};

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        ccc10_lane #(
            .MODULUS (MODULUS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_coeff (w_coeffs[g*COEFF_W +: COEFF_W]),
            .i_code  (i_req.packed_in[g*CODE_W +: CODE_W]),
            .o_cmp   (w_cmp[g*CODE_W +: CODE_W]),
            .o_dec   (w_dec[g*COEFF_W +: COEFF_W])
        );
    end

    always_comb begin
        n_rsp = '0;
        if (r_t2 == REQ_DECOMPRESS) begin
            n_rsp.value_0 = w_dec[0*COEFF_W +: COEFF_W];
            n_rsp.value_1 = w_dec[1*COEFF_W +: COEFF_W];
            n_rsp.value_2 = w_dec[2*COEFF_W +: COEFF_W];
            n_rsp.value_3 = w_dec[3*COEFF_W +: COEFF_W];
        end else begin
            n_rsp.packed_out = w_cmp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start & ~o_busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_t1  <= i_req.req_type;
        r_t2  <= r_t1;
        r_rsp <= n_rsp;
    end

    assign o_done = r_v3;
    assign o_rsp  = r_rsp;

endmodule
`default_nettype wire

// ===== design/ccc10_lane.sv =====
`default_nettype none
module ccc10_lane
    import ccc10_pkg::*;
#(
    parameter int unsigned MODULUS = MODULUS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic [COEFF_W-1:0] i_coeff,
    input  wire logic [CODE_W-1:0]  i_code,
    output logic      [CODE_W-1:0]  o_cmp,
    output logic      [COEFF_W-1:0] o_dec
);

    localparam int unsigned MOD_W  = $clog2(MODULUS + 1);
    localparam int unsigned F_W    = COEFF_W + CODE_W + 1;
    localparam int unsigned PC_W   = F_W + CMP_MUL_W;
    localparam int unsigned B_W    = PC_W - CMP_SHIFT1;
    localparam int unsigned S_W    = F_W + 1;
    localparam int unsigned PD_W   = CODE_W + MOD_W;

    localparam logic [F_W-1:0]       HALF_Q  = F_W'(MODULUS / 2);
    localparam logic [CMP_MUL_W-1:0] MUL_C   = CMP_MUL_W'(CMP_MUL);
    localparam logic [MOD_W-1:0]     MOD_C   = MOD_W'(MODULUS);
    localparam logic [PD_W-1:0]      ROUND_C = PD_W'(DEC_ROUND);

    logic [F_W-1:0]    r_f;
    logic [CODE_W-1:0] r_code;
    logic [F_W-1:0]    r_f2;
    logic [PC_W-1:0]   r_pc;
    logic [PD_W-1:0]   r_pd;

    logic [F_W-1:0]    n_f;
    logic [PC_W-1:0]   n_pc;
    logic [PD_W-1:0]   n_pd;
    logic [B_W-1:0]    w_b;
    logic [S_W-1:0]    w_sum;
    logic [PD_W-1:0]   w_dsum;

    assign n_f  = {1'b0, i_coeff, {CODE_W{1'b0}}} + HALF_Q;
    assign n_pc = PC_W'(r_f) * PC_W'(MUL_C);
    assign n_pd = PD_W'(r_code) * PD_W'(MOD_C);

    always_ff @(posedge i_clk) begin
        r_f    <= n_f;
        r_code <= i_code;
        r_f2   <= r_f;
        r_pc   <= n_pc;
        r_pd   <= n_pd;
    end

    assign w_b    = r_pc[PC_W-1:CMP_SHIFT1];
    assign w_sum  = S_W'(r_f2) + S_W'(w_b);
    assign w_dsum = r_pd + ROUND_C;
    assign o_cmp  = w_sum[CMP_SHIFT2+CODE_W-1:CMP_SHIFT2];
    assign o_dec  = w_dsum[CODE_W+COEFF_W-1:CODE_W];

endmodule
`default_nettype wire
